// File: sv/spm_pkg.sv
`timescale 1ns / 1ps
package spm_pkg;

  localparam int MAX_PAT_DEF = 16;

  localparam logic [1:0] OP_PAT = 2'd0;
  localparam logic [1:0] OP_TXT = 2'd1;
  localparam logic [1:0] OP_FIN = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic found;
    logic pattern_overflow;
  } out_item_t;

  typedef struct packed {
    logic shift_pat;
    logic shift_txt;
    logic clear;
  } cell_ctl_t;

endpackage

// File: sv/spm_cell.sv
`timescale 1ns / 1ps
module spm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spm_pkg::cell_ctl_t ctl,
  input  logic [7:0]         pat_in,
  input  logic               pv_in,
  input  logic [7:0]         txt_in,
  input  logic               tv_in,
  output logic [7:0]         pat_out,
  output logic               pv_out,
  output logic [7:0]         txt_out,
  output logic               tv_out,
  output logic               hit
);
  import spm_pkg::*;

  logic [7:0] pat_r, pat_nxt;
  logic [7:0] txt_r, txt_nxt;
  logic       pv_r, pv_nxt;
  logic       tv_r, tv_nxt;

  always_comb begin
    pat_nxt = ctl.shift_pat ? pat_in : pat_r;
    pv_nxt  = ctl.shift_pat ? pv_in  : pv_r;
    txt_nxt = ctl.shift_txt ? txt_in : txt_r;
    tv_nxt  = ctl.shift_txt ? tv_in  : tv_r;
    if (ctl.clear) begin
      pv_nxt = 1'b0;
      tv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      tv_r <= 1'b0;
    end else begin
      pv_r <= pv_nxt;
      tv_r <= tv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
    txt_r <= txt_nxt;
  end

  // compare against the byte arriving in this cell on the current text item
  assign hit     = !pv_r || (tv_in && (pat_r == txt_in));
  assign pat_out = pat_r;
  assign pv_out  = pv_r;
  assign txt_out = txt_r;
  assign tv_out  = tv_r;

endmodule

// File: sv/substring_presence_matcher.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | in_item  (opcode, data_byte)
// out_    | output    | out_valid/out_stall| out_item (found, pattern_overflow)
//
// Pattern and text items shift their row one cell; a full pattern row holds.
// A finish item yields one result in the next cycle from the output register.
// Reset and finish clear all valid bits of the cell row and the sticky flags.
// in_stall is high only while a result is held and out_stall is high.
module substring_presence_matcher #(
  parameter int MAX_PAT = spm_pkg::MAX_PAT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  spm_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output spm_pkg::out_item_t  out_item
);
  import spm_pkg::*;

  logic [7:0]   pat_q [MAX_PAT];
  logic [7:0]   txt_q [MAX_PAT];
  logic [MAX_PAT-1:0] pv_q, tv_q, hit;
  logic [7:0]   pat_d [MAX_PAT];
  logic [7:0]   txt_d [MAX_PAT];
  logic [MAX_PAT-1:0] pv_d, tv_d;

  cell_ctl_t ctl;
  logic      in_acc;
  logic      is_pat, is_txt, is_fin;
  logic      match_r, match_nxt;
  logic      ovf_r, ovf_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    is_pat = 1'b0;
    is_txt = 1'b0;
    is_fin = 1'b0;
    case (in_item.opcode)
      OP_PAT:  is_pat = in_acc;
      OP_TXT:  is_txt = in_acc;
      OP_FIN:  is_fin = in_acc;
      default: ;
    endcase
  end

  assign ctl.shift_pat = is_pat && !pv_q[MAX_PAT-1];
  assign ctl.shift_txt = is_txt;
  assign ctl.clear     = is_fin;

  genvar i;
  generate
    for (i = 0; i < MAX_PAT; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign pat_d[i] = in_item.data_byte;
        assign pv_d[i]  = 1'b1;
        assign txt_d[i] = in_item.data_byte;
        assign tv_d[i]  = 1'b1;
      end else begin : g_link
        assign pat_d[i] = pat_q[i-1];
        assign pv_d[i]  = pv_q[i-1];
        assign txt_d[i] = txt_q[i-1];
        assign tv_d[i]  = tv_q[i-1];
      end
      spm_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .pat_in  (pat_d[i]),
        .pv_in   (pv_d[i]),
        .txt_in  (txt_d[i]),
        .tv_in   (tv_d[i]),
        .pat_out (pat_q[i]),
        .pv_out  (pv_q[i]),
        .txt_out (txt_q[i]),
        .tv_out  (tv_q[i]),
        .hit     (hit[i])
      );
    end
  endgenerate

  always_comb begin
    match_nxt     = match_r || (is_txt && pv_q[0] && (&hit));
    ovf_nxt       = ovf_r || (is_pat && pv_q[MAX_PAT-1]);
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (is_fin) begin
      out_valid_nxt                 = 1'b1;
      out_item_nxt.found            = !pv_q[0] || match_r;
      out_item_nxt.pattern_overflow = ovf_r;
      match_nxt                     = 1'b0;
      ovf_nxt                       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r     <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      match_r     <= match_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    is_fin |=> out_valid_r)
    else $error("finish item gave no result");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> pv_q[MAX_PAT-1])
    else $error("overflow flagged with pattern row not full");

  a_pv_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    pv_q[MAX_PAT-1] |-> pv_q[0])
    else $error("pattern valid bits not contiguous");

  a_match_needs_pat: assert property (@(posedge clk) disable iff (!rst_n)
    match_r |-> pv_q[0])
    else $error("match flagged with empty pattern");

endmodule

// File: dv/spm_checker.sv
`timescale 1ns / 1ps
module spm_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  spm_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  spm_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 reports_due
);
  import spm_pkg::*;

  localparam int DEPTH = MAX_PAT_DEF;

  logic [7:0] pat_bytes [DEPTH];
  int         pat_len;
  logic [7:0] txt_win [DEPTH];
  int         txt_count;
  bit         hit_flag;
  bit         ovf_flag;
  out_item_t  report_queue [$];

  initial begin
    fail_count  = 0;
    reports_due = 0;
  end

  task automatic clear_matcher();
    int k;
    for (k = 0; k < DEPTH; k++) begin
      pat_bytes[k] = 8'd0;
      txt_win[k]   = 8'd0;
    end
    pat_len   = 0;
    txt_count = 0;
    hit_flag  = 1'b0;
    ovf_flag  = 1'b0;
  endtask

  function automatic bit tail_matches();
    int k;
    if (pat_len == 0 || txt_count < pat_len) return 1'b0;
    for (k = 0; k < pat_len; k++) begin
      if (pat_bytes[k] != txt_win[pat_len - 1 - k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic apply_item(input in_item_t it);
    out_item_t rep;
    int k;
    case (it.opcode)
      OP_PAT: begin
        if (pat_len < DEPTH) begin
          pat_bytes[pat_len] = it.data_byte;
          pat_len++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      OP_TXT: begin
        for (k = DEPTH - 1; k > 0; k--) txt_win[k] = txt_win[k - 1];
        txt_win[0] = it.data_byte;
        if (txt_count < DEPTH) txt_count++;
        if (tail_matches()) hit_flag = 1'b1;
      end
      OP_FIN: begin
        rep.found            = (pat_len == 0) || hit_flag;
        rep.pattern_overflow = ovf_flag;
        report_queue.push_back(rep);
        clear_matcher();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      clear_matcher();
      report_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (report_queue.size() == 0) begin
          $error("out_item: result with no finish item pending %s",
                 $sformatf("(found %0b, pattern_overflow %0b)",
                           out_item.found, out_item.pattern_overflow));
          fail_count++;
        end else begin
          want = report_queue.pop_front();
          if (out_item.found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, out_item.found);
            fail_count++;
          end
          if (out_item.pattern_overflow !== want.pattern_overflow) begin
            $error("pattern_overflow: expected %0b, actual %0b",
                   want.pattern_overflow, out_item.pattern_overflow);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) apply_item(in_item);
    end
    reports_due <= report_queue.size();
  end

endmodule

// File: dv/substring_presence_matcher_tb.sv
`timescale 1ns / 1ps
module substring_presence_matcher_tb;
  import spm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 800;
  localparam int STUCK_LIMIT  = 4000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  int        fail_count;
  int        reports_due;
  int        idle_pct;
  int        stall_pct;
  bit        calm;
  int        items_sent;
  int        stuck_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  substring_presence_matcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  spm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .reports_due (reports_due)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stall_gen
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        n = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0, 1: return 0;
      2: return 15;
      default: return 50;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte(input bit narrow);
    logic [31:0] r;
    r = $urandom;
    return narrow ? {6'd0, r[1:0]} : r[7:0];
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] value);
    int n;
    in_valid <= 1'b1;
    in_item  <= in_item_t'{op, value};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      n = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // pattern, then text with the pattern sometimes planted at a random spot, then finish
  task automatic run_search();
    logic [7:0] pat [18];
    int plen, tlen, at, k, j;
    bit narrow;
    plen   = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 18);
    narrow = $urandom_range(0, 9) < 6;
    tlen   = $urandom_range(0, 20);
    at     = ($urandom_range(0, 1) == 1) ? $urandom_range(0, tlen) : -1;
    for (k = 0; k < 18; k++) pat[k] = rand_byte(narrow);
    for (k = 0; k < plen; k++) send_item(OP_PAT, pat[k]);
    for (k = 0; k <= tlen; k++) begin
      if (k == at) begin
        for (j = 0; j < plen && j < MAX_PAT_DEF; j++) send_item(OP_TXT, pat[j]);
      end
      if (k < tlen) begin
        if ($urandom_range(0, 19) == 0) send_item(OP_UNUSED, rand_byte(1'b0));
        else if ($urandom_range(0, 29) == 0) send_item(OP_PAT, rand_byte(narrow));
        send_item(OP_TXT, rand_byte(narrow));
      end
    end
    send_item(OP_FIN, rand_byte(1'b0));
  endtask

  initial begin : stimulus
    int k;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    calm       = 1'b0;
    idle_pct   = 30;
    stall_pct  = 30;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern
    send_item(OP_FIN, 8'hFF);
    // unused opcode must not act as text
    send_item(OP_PAT, 8'h41);
    send_item(OP_UNUSED, 8'h41);
    send_item(OP_FIN, 8'h00);
    // pattern longer than text so far
    send_item(OP_PAT, 8'h00);
    send_item(OP_PAT, 8'hFF);
    send_item(OP_TXT, 8'h00);
    send_item(OP_FIN, 8'h00);
    // pattern byte after text; earlier match stays
    send_item(OP_PAT, 8'h00);
    send_item(OP_TXT, 8'h00);
    send_item(OP_PAT, 8'hFF);
    send_item(OP_TXT, 8'hFF);
    send_item(OP_TXT, 8'h11);
    send_item(OP_FIN, 8'h00);
    // pattern too long
    for (k = 0; k <= MAX_PAT_DEF; k++) send_item(OP_PAT, 8'(k * 17));
    send_item(OP_FIN, 8'hAA);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= RANDOM_ITEMS * 7 / 8) calm = 1'b1;
      idle_pct  = pick_pct();
      stall_pct = pick_pct();
      run_search();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
